// ----- hw/rtl/tsd_pkg.sv -----
`timescale 1ns / 1ps

package tsd_pkg;

    localparam int TENTHS_W = 14;
    localparam int DIGIT_W  = 4;
    localparam int SEG_W    = 8;

    // Item kinds as they arrive on the input channel.
    typedef enum logic {
        KIND_READING = 1'b0,
        KIND_TICK    = 1'b1
    } t_kind;

    // Scan positions, leftmost digit first.
    localparam logic [1:0] POS_HUNDREDS = 2'd0;
    localparam logic [1:0] POS_TENS     = 2'd1;
    localparam logic [1:0] POS_UNITS    = 2'd2;
    localparam logic [1:0] POS_TENTHS   = 2'd3;

    localparam logic [SEG_W-1:0]    SEG_MINUS   = 8'hBF;
    localparam logic [SEG_W-1:0]    SEG_DP_MASK = 8'h7F;
    localparam logic [SEG_W-1:0]    SEG_BLANK   = 8'hFF;
    localparam logic [TENTHS_W-1:0] TENTHS_MAX  = 14'd9999;
    localparam logic [15:0]         DWELL_RESET = 16'd1000;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        t_kind               kind;
        logic                neg;
        logic [TENTHS_W-1:0] tenths;
        logic [DIGIT_W-1:0]  d_thou;
        logic [DIGIT_W-1:0]  d_hund;
        logic [DIGIT_W-1:0]  d_tens;
        logic [DIGIT_W-1:0]  d_unit;
    } t_item;

    // Active-low common-anode glyphs, decimal point off.
    function automatic logic [SEG_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] g;
        case (d)
            4'd0: g = 8'hC0;
            4'd1: g = 8'hF9;
            4'd2: g = 8'hA4;
            4'd3: g = 8'hB0;
            4'd4: g = 8'h99;
            4'd5: g = 8'h92;
            4'd6: g = 8'h82;
            4'd7: g = 8'hF8;
            4'd8: g = 8'h80;
            4'd9: g = 8'h90;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

endpackage

// ----- hw/rtl/temperature_seven_segment_driver.sv -----
`timescale 1ns / 1ps

// Temperature display driver for a four-digit common-anode seven-segment panel.
// Input channel (i_in_valid / o_in_ready): each transaction is either a sensor
// reading (i_kind = 0, i_raw_reading in signed 1/16 degree steps) or a scan tick
// (i_kind = 1). Every input transaction yields exactly one output transaction on
// (o_out_valid / i_out_ready): the lit digit, its active-low segments, the stored
// sign and the stored magnitude in tenths of a degree, saturated at 9999 tenths.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes dwell_ticks, the
// number of ticks each digit stays lit; write it only while the block is idle.
// Each result passes two front-end stages (scaling, then decimal split by
// reciprocal multiply) and the queue, and the back end loads its output
// register as it pops the queue. Throughput is one transaction per cycle
// while the receiver does not stall. When it stalls, the output register
// holds its result, the queue fills, and then the front end stops accepting;
// nothing is dropped.
// Reset (synchronous, active low) empties the pipeline and queue, clears the
// stored reading to positive zero, returns the scan to the leftmost digit and
// sets dwell_ticks to 1000.
module temperature_seven_segment_driver #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  logic signed [15:0]   i_raw_reading,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [3:0]           o_digit_select,
    output logic [7:0]           o_segments,
    output logic                 o_is_negative,
    output logic [13:0]          o_tenths_value,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_dwell_ticks
);

    logic [15:0] r_dwell_ticks;

    logic           w_front_valid;
    logic           w_front_ready;
    tsd_pkg::t_item w_front_item;
    logic           w_queue_valid;
    logic           w_queue_ready;
    tsd_pkg::t_item w_queue_item;

    // The configuration register accepts a write in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_ticks <= tsd_pkg::DWELL_RESET;
        end else if (i_cfg_valid) begin
            r_dwell_ticks <= i_cfg_dwell_ticks;
        end
    end

    // Front end: accepts transactions and converts readings to decimal digits.
    tsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_kind        (i_kind),
        .i_raw_reading (i_raw_reading),
        .o_valid       (w_front_valid),
        .i_ready       (w_front_ready),
        .o_item        (w_front_item)
    );

    // Queue between the two halves so each side can stall independently.
    tsd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_item  (w_front_item),
        .o_valid (w_queue_valid),
        .i_ready (w_queue_ready),
        .o_item  (w_queue_item)
    );

    // Back end: holds the display state, runs the scan and drives the result.
    tsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_queue_valid),
        .o_ready        (w_queue_ready),
        .i_item         (w_queue_item),
        .i_dwell_ticks  (r_dwell_ticks),
        .o_valid        (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_digit_select (o_digit_select),
        .o_segments     (o_segments),
        .o_is_negative  (o_is_negative),
        .o_tenths_value (o_tenths_value)
    );

endmodule

// ----- hw/rtl/tsd_front.sv -----
`timescale 1ns / 1ps

module tsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic signed [15:0]  i_raw_reading,
    output logic                o_valid,
    input  logic                i_ready,
    output tsd_pkg::t_item      o_item
);

    // Stage 1: magnitude in tenths, floor(|raw| * 5 / 8), saturated.
    logic [16:0] w_mag;
    logic [19:0] w_scaled;
    logic [16:0] w_quot;
    logic [tsd_pkg::TENTHS_W-1:0] w_tenths;

    logic                         r_s1_valid;
    tsd_pkg::t_kind               r_s1_kind;
    logic                         r_s1_neg;
    logic [tsd_pkg::TENTHS_W-1:0] r_s1_tenths;

    logic           r_s2_valid;
    tsd_pkg::t_item r_s2_item;

    logic w_s2_adv;
    logic w_s1_adv;

    always_comb begin
        if (i_raw_reading[15]) begin
            w_mag = 17'd0 - {i_raw_reading[15], i_raw_reading};
        end else begin
            w_mag = {1'b0, i_raw_reading};
        end
        w_scaled = {1'b0, w_mag, 2'b00} + {3'b000, w_mag};
        w_quot   = w_scaled[19:3];
        if (w_quot > 17'(tsd_pkg::TENTHS_MAX)) begin
            w_tenths = tsd_pkg::TENTHS_MAX;
        end else begin
            w_tenths = w_quot[tsd_pkg::TENTHS_W-1:0];
        end
    end

    assign w_s2_adv = !r_s2_valid || i_ready;
    assign w_s1_adv = !r_s1_valid || w_s2_adv;
    assign o_ready  = w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && i_valid) begin
            r_s1_kind   <= tsd_pkg::t_kind'(i_kind);
            r_s1_neg    <= i_raw_reading[15];
            r_s1_tenths <= w_tenths;
        end
    end

    // Stage 2: decimal split by reciprocal multiplication. For values up to
    // 9999 each quotient is exact; the thousands digit is its quotient, and every
    // other digit is a quotient minus ten times the next coarser quotient.
    logic [26:0] w_p_thou;
    logic [25:0] w_p_hund;
    logic [25:0] w_p_tens;
    logic [3:0]  w_q_thou;
    logic [6:0]  w_q_hund;
    logic [9:0]  w_q_tens;
    logic [6:0]  w_r_hund;
    logic [9:0]  w_r_tens;
    logic [tsd_pkg::TENTHS_W-1:0] w_r_unit;
    tsd_pkg::t_item w_item;

    always_comb begin
        w_p_thou = 27'(r_s1_tenths) * 27'd8389;
        w_p_hund = 26'(r_s1_tenths) * 26'd5243;
        w_p_tens = 26'(r_s1_tenths) * 26'd6554;
        w_q_thou = w_p_thou[26:23];
        w_q_hund = w_p_hund[25:19];
        w_q_tens = w_p_tens[25:16];
        w_r_hund = w_q_hund - 7'(w_q_thou) * 7'd10;
        w_r_tens = w_q_tens - 10'(w_q_hund) * 10'd10;
        w_r_unit = r_s1_tenths - 14'(w_q_tens) * 14'd10;

        w_item.kind   = r_s1_kind;
        w_item.neg    = r_s1_neg;
        w_item.tenths = r_s1_tenths;
        w_item.d_thou = w_q_thou;
        w_item.d_hund = w_r_hund[3:0];
        w_item.d_tens = w_r_tens[3:0];
        w_item.d_unit = w_r_unit[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv && r_s1_valid) begin
            r_s2_item <= w_item;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;

endmodule

// ----- hw/rtl/tsd_fifo.sv -----
`timescale 1ns / 1ps

module tsd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tsd_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output tsd_pkg::t_item o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tsd_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    logic w_push;
    logic w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/tsd_back.sv -----
`timescale 1ns / 1ps

module tsd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  tsd_pkg::t_item                i_item,
    input  logic [15:0]                   i_dwell_ticks,
    output logic                          o_valid,
    input  logic                          i_out_ready,
    output logic [3:0]                    o_digit_select,
    output logic [tsd_pkg::SEG_W-1:0]     o_segments,
    output logic                          o_is_negative,
    output logic [tsd_pkg::TENTHS_W-1:0]  o_tenths_value
);

    // Display state.
    logic                         r_neg, n_neg;
    logic [tsd_pkg::TENTHS_W-1:0] r_tenths, n_tenths;
    logic [tsd_pkg::DIGIT_W-1:0]  r_d_thou, n_d_thou;
    logic [tsd_pkg::DIGIT_W-1:0]  r_d_hund, n_d_hund;
    logic [tsd_pkg::DIGIT_W-1:0]  r_d_tens, n_d_tens;
    logic [tsd_pkg::DIGIT_W-1:0]  r_d_unit, n_d_unit;
    logic [1:0]                   r_scan, n_scan;
    logic [15:0]                  r_count, n_count;

    // Output register.
    logic                         r_out_valid, n_out_valid;
    logic [3:0]                   r_out_sel, n_out_sel;
    logic [tsd_pkg::SEG_W-1:0]    r_out_seg, n_out_seg;
    logic                         r_out_neg, n_out_neg;
    logic [tsd_pkg::TENTHS_W-1:0] r_out_tenths, n_out_tenths;

    logic        w_pop;
    logic        w_is_reading;
    logic        w_is_tick;
    logic [15:0] w_limit;
    logic [16:0] w_next_count;
    logic        w_wrap;

    assign o_ready      = !r_out_valid || i_out_ready;
    assign w_pop        = i_valid && o_ready;
    assign w_is_reading = (i_item.kind == tsd_pkg::KIND_READING);
    assign w_is_tick    = (i_item.kind == tsd_pkg::KIND_TICK);
    assign w_limit      = (i_dwell_ticks == 16'd0) ? 16'd1 : i_dwell_ticks;
    assign w_next_count = {1'b0, r_count} + 17'd1;
    assign w_wrap       = (w_next_count >= {1'b0, w_limit});

    // State update: a reading replaces the value, a tick steps the dwell count or, at its end, the scan.
    always_comb begin
        n_neg    = r_neg;
        n_tenths = r_tenths;
        n_d_thou = r_d_thou;
        n_d_hund = r_d_hund;
        n_d_tens = r_d_tens;
        n_d_unit = r_d_unit;
        n_scan   = r_scan;
        n_count  = r_count;
        if (w_pop && w_is_reading) begin
            n_neg    = i_item.neg;
            n_tenths = i_item.tenths;
            n_d_thou = i_item.d_thou;
            n_d_hund = i_item.d_hund;
            n_d_tens = i_item.d_tens;
            n_d_unit = i_item.d_unit;
        end
        if (w_pop && w_is_tick) begin
            if (w_wrap) begin
                n_scan  = r_scan + 2'd1;
                n_count = '0;
            end else begin
                n_count = w_next_count[15:0];
            end
        end
    end

    // Result: the digit lit now, built from the value after this item.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_sel    = r_out_sel;
        n_out_seg    = r_out_seg;
        n_out_neg    = r_out_neg;
        n_out_tenths = r_out_tenths;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_pop) begin
            n_out_valid  = 1'b1;
            n_out_sel    = 4'b1000 >> r_scan;
            n_out_neg    = n_neg;
            n_out_tenths = n_tenths;
            case (r_scan)
                tsd_pkg::POS_HUNDREDS: begin
                    n_out_seg = n_neg ? tsd_pkg::SEG_MINUS : tsd_pkg::digit_glyph(n_d_thou);
                end
                tsd_pkg::POS_TENS: begin
                    n_out_seg = tsd_pkg::digit_glyph(n_d_hund);
                end
                tsd_pkg::POS_UNITS: begin
                    n_out_seg = tsd_pkg::digit_glyph(n_d_tens) & tsd_pkg::SEG_DP_MASK;
                end
                tsd_pkg::POS_TENTHS: begin
                    n_out_seg = tsd_pkg::digit_glyph(n_d_unit);
                end
                default: begin
                    n_out_seg = tsd_pkg::SEG_BLANK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg       <= 1'b0;
            r_tenths    <= '0;
            r_d_thou    <= '0;
            r_d_hund    <= '0;
            r_d_tens    <= '0;
            r_d_unit    <= '0;
            r_scan      <= tsd_pkg::POS_HUNDREDS;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_neg       <= n_neg;
            r_tenths    <= n_tenths;
            r_d_thou    <= n_d_thou;
            r_d_hund    <= n_d_hund;
            r_d_tens    <= n_d_tens;
            r_d_unit    <= n_d_unit;
            r_scan      <= n_scan;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sel    <= n_out_sel;
        r_out_seg    <= n_out_seg;
        r_out_neg    <= n_out_neg;
        r_out_tenths <= n_out_tenths;
    end

    assign o_valid        = r_out_valid;
    assign o_digit_select = r_out_sel;
    assign o_segments     = r_out_seg;
    assign o_is_negative  = r_out_neg;
    assign o_tenths_value = r_out_tenths;

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot(r_out_sel))
        else $error("digit select is not one-hot on a valid result");

    a_reading_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_is_reading) |=>
            (r_tenths == $past(i_item.tenths)) && (r_neg == $past(i_item.neg)))
        else $error("reading not stored after its transaction");

    a_scan_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_is_tick && w_wrap) |=>
            (r_scan == $past(r_scan) + 2'd1) && (r_count == 16'd0))
        else $error("scan did not advance at the end of a dwell period");

    a_tenths_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tenths <= tsd_pkg::TENTHS_MAX)
        else $error("stored magnitude above saturation limit");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // The run is bounded by this many clock cycles; a correct run needs a
    // small fraction of it even with the heaviest back-pressure.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles to wait after the last result so the pipeline settles.
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // One pending sensor-side transaction: a reading or a scan tick.
    typedef struct {
        tsd_pkg::t_kind kind;
        logic [15:0]    raw;
    } t_sensor_item;

    // One expected display transaction, field by field.
    typedef struct {
        logic [tsd_pkg::DIGIT_W-1:0]  digit_sel;
        logic [tsd_pkg::SEG_W-1:0]    segs;
        logic                         neg;
        logic [tsd_pkg::TENTHS_W-1:0] tenths;
    } t_display;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    // Input channel, driven only by the sensor driver below.
    logic           in_valid = 1'b0;
    tsd_pkg::t_kind kind_q = tsd_pkg::KIND_READING;
    logic [15:0]    raw_q = 16'h0000;

    // Output channel ready, driven only by the display monitor.
    logic        out_ready = 1'b0;

    // Configuration channel, driven only by the stimulus sequence.
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_dwell = 16'h0000;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [3:0]          o_digit_select;
    logic [7:0]          o_segments;
    logic                o_is_negative;
    logic [13:0]         o_tenths_value;
    logic                o_cfg_ready;

    // Transactions waiting to be offered, and the display results still owed.
    t_sensor_item pending_sensor_items[$];
    t_display     expected_display[$];

    // Our own copy of the display state and the dwell register.
    logic [15:0]                  dwell_setting = tsd_pkg::DWELL_RESET;
    logic [tsd_pkg::TENTHS_W-1:0] tenths_shadow = '0;
    logic                         neg_shadow = 1'b0;
    logic [1:0]                   scan_shadow = tsd_pkg::POS_HUNDREDS;
    logic [15:0]                  dwell_count_shadow = '0;

    // Idle percentages for each side, changed between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int mismatch_count = 0;
    int results_checked = 0;
    int readings_sent = 0;
    int ticks_sent = 0;
    int scan_steps = 0;
    int cycle_count = 0;

    temperature_seven_segment_driver dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (kind_q),
        .i_raw_reading     (raw_q),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_digit_select    (o_digit_select),
        .o_segments        (o_segments),
        .o_is_negative     (o_is_negative),
        .o_tenths_value    (o_tenths_value),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_dwell_ticks (cfg_dwell)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Active-low common-anode glyph for one decimal digit, decimal point dark.
    function automatic logic [tsd_pkg::SEG_W-1:0] seven_seg(input int digit);
        case (digit)
            0: return 8'hC0;
            1: return 8'hF9;
            2: return 8'hA4;
            3: return 8'hB0;
            4: return 8'h99;
            5: return 8'h92;
            6: return 8'h82;
            7: return 8'hF8;
            8: return 8'h80;
            default: return 8'h90;
        endcase
    endfunction

    // Applies one accepted sensor transaction to the shadow state and queues
    // the display transaction it must produce. A reading updates the sign and
    // the magnitude before the lit digit is shown; a tick shows the lit digit
    // first and then advances the dwell counter.
    task automatic predict_display(input tsd_pkg::t_kind kind, input logic [15:0] raw);
        logic [16:0] magnitude;
        logic [19:0] scaled;
        logic [16:0] count_plus;
        logic [15:0] dwell_limit;
        int          t;
        t_display    d;
        if (kind == tsd_pkg::KIND_READING) begin
            neg_shadow = raw[15];
            // The most negative word has a magnitude of 32768, hence 17 bits.
            magnitude = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
            // Sixteenths to tenths is exactly floor(x * 5 / 8).
            scaled = ({3'b000, magnitude} * 20'd5) >> 3;
            tenths_shadow = (scaled > tsd_pkg::TENTHS_MAX) ?
                            tsd_pkg::TENTHS_MAX : scaled[tsd_pkg::TENTHS_W-1:0];
        end
        t = tenths_shadow;
        d.digit_sel = 4'b1000 >> scan_shadow;
        d.neg = neg_shadow;
        d.tenths = tenths_shadow;
        case (scan_shadow)
            tsd_pkg::POS_HUNDREDS:
                d.segs = neg_shadow ? tsd_pkg::SEG_MINUS : seven_seg((t / 1000) % 10);
            tsd_pkg::POS_TENS:
                d.segs = seven_seg((t / 100) % 10);
            tsd_pkg::POS_UNITS:
                d.segs = seven_seg((t / 10) % 10) & tsd_pkg::SEG_DP_MASK;
            default:
                d.segs = seven_seg(t % 10);
        endcase
        expected_display.push_back(d);
        if (kind == tsd_pkg::KIND_TICK) begin
            // A dwell of zero behaves like one; a dwell lowered below the
            // current count makes the very next tick advance the scan.
            dwell_limit = (dwell_setting == 16'd0) ? 16'd1 : dwell_setting;
            count_plus = {1'b0, dwell_count_shadow} + 17'd1;
            if (count_plus >= {1'b0, dwell_limit}) begin
                scan_shadow = scan_shadow + 2'd1;
                dwell_count_shadow = '0;
                scan_steps++;
            end else begin
                dwell_count_shadow = count_plus[15:0];
            end
            ticks_sent++;
        end else begin
            readings_sent++;
        end
    endtask

    // Sensor driver. A transaction completes at an edge where valid and ready
    // are both high; only then is it predicted. A waiting transaction is held
    // unchanged. Otherwise the next one is offered unless this cycle idles.
    always @(posedge i_clk) begin : sensor_driver
        logic         taken;
        t_sensor_item item;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && o_in_ready;
            if (taken) begin
                predict_display(kind_q, raw_q);
            end
            if (in_valid && !taken) begin
                // Still waiting for the block; keep valid and payload as they are.
            end else if (pending_sensor_items.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                item = pending_sensor_items.pop_front();
                in_valid <= 1'b1;
                kind_q <= item.kind;
                raw_q <= item.raw;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Display monitor. Every completed output transaction is checked against
    // the oldest expectation; ready is then redrawn for the next cycle.
    always @(posedge i_clk) begin : display_monitor
        t_display want;
        if (i_rst_n && o_out_valid && out_ready) begin
            results_checked++;
            if (expected_display.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected display transaction: sel=%h seg=%h neg=%b tenths=%0d",
                             o_digit_select, o_segments, o_is_negative, o_tenths_value);
                end
            end else begin
                want = expected_display.pop_front();
                if (o_digit_select !== want.digit_sel || o_segments !== want.segs ||
                    o_is_negative !== want.neg || o_tenths_value !== want.tenths) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("display mismatch at %0t ns:", $time);
                        $display("  expected sel=%h seg=%h neg=%b tenths=%0d",
                                 want.digit_sel, want.segs, want.neg, want.tenths);
                        $display("  actual   sel=%h seg=%h neg=%b tenths=%0d",
                                 o_digit_select, o_segments, o_is_negative, o_tenths_value);
                    end
                end
            end
        end
        out_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     CYCLE_LIMIT, expected_display.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_reading(input logic [15:0] raw);
        t_sensor_item item;
        item.kind = tsd_pkg::KIND_READING;
        item.raw = raw;
        pending_sensor_items.push_back(item);
    endtask

    task automatic add_ticks(input int count);
        t_sensor_item item;
        item.kind = tsd_pkg::KIND_TICK;
        // The reading field is ignored on a tick, so let it carry noise.
        for (int i = 0; i < count; i++) begin
            item.raw = 16'($urandom);
            pending_sensor_items.push_back(item);
        end
    endtask

    // Random mix: ticks slightly more often than readings so the scan moves,
    // and readings drawn from the whole word, from around zero where every
    // digit is meaningful, from around the saturation point and from both extremes.
    task automatic add_random(input int count);
        logic [15:0] raw;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 55) begin
                add_ticks(1);
            end else begin
                case ($urandom_range(3))
                    0: raw = 16'($urandom);
                    1: raw = 16'($urandom_range(3200) - 1600);
                    2: begin
                        raw = 16'd15996 + 16'($urandom_range(8));
                        if ($urandom_range(1) == 1) raw = -raw;
                    end
                    default: raw = ($urandom_range(1) == 1) ? 16'h8000 : 16'h7FFF;
                endcase
                add_reading(raw);
            end
        end
    endtask

    // Waits until every offered transaction has completed and every result has
    // been seen, then lets the pipeline settle so the block is truly idle.
    task automatic wait_idle();
        while (pending_sensor_items.size() != 0 || in_valid || expected_display.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the dwell register; only called while the block is idle, so the
    // shadow copy can change at the moment the write completes.
    task automatic write_dwell(input logic [15:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_dwell <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        dwell_setting = value;
        cfg_valid <= 1'b0;
    endtask

    // Stimulus sequence.
    initial begin : stimulus
        logic [15:0] dwell_plan[6];
        dwell_plan = '{16'd1, 16'd2, 16'd3, 16'd0, 16'd5, 16'd65535};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset dwell of 1000: the first tick shows the
        // cleared state, then the sign and saturation corners.
        add_ticks(1);
        add_reading(16'd0);
        add_reading(16'd16);
        add_reading(16'hFFFF);
        add_reading(16'h7FFF);
        add_reading(16'h8000);
        add_reading(16'd15998);
        add_reading(16'd15999);
        add_reading(16'd16000);
        add_reading(16'd1);
        wait_idle();

        // With a dwell of one every tick moves the scan across all four
        // digits: a positive value with a full set of digits, then a minus sign.
        write_dwell(16'd1);
        add_reading(16'd1975);
        add_ticks(4);
        add_reading(-16'sd800);
        add_ticks(4);
        wait_idle();

        // Dwell lowered below the current count: the next tick advances at once.
        write_dwell(16'd20);
        add_ticks(6);
        wait_idle();
        write_dwell(16'd2);
        add_ticks(2);
        wait_idle();

        // Random part: three back-pressure phases, each walking through a set
        // of dwell values that includes zero and the largest setting.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 73;
                end
                1: begin
                    send_idle_pct = 73;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < 6; s++) begin
                write_dwell(dwell_plan[s]);
                add_random(100);
                wait_idle();
            end
        end

        $display("covered %0d readings and %0d ticks, %0d scan advances, %0d results checked",
                 readings_sent, ticks_sent, scan_steps, results_checked);
        $display("dwell settings 0 to 65535 under three back-pressure patterns");
        if (mismatch_count == 0 && expected_display.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches in total", mismatch_count);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_front.sv
hw/rtl/tsd_fifo.sv
hw/rtl/tsd_back.sv
hw/rtl/temperature_seven_segment_driver.sv
tb/sv/testbench.sv
